>>> rtl/ffla_pkg.sv
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared types, sizes and codes of the first-come first-served lock arbiter.
// ----------------------------------------------------------------------------
package ffla_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int REQUESTERS  = 16;

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QSUM_W = QIDX_W + 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int REQ_W  = 4;

  localparam logic [1:0] CMD_LOCK   = 2'd0;
  localparam logic [1:0] CMD_TRY    = 2'd1;
  localparam logic [1:0] CMD_UNLOCK = 2'd2;

  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_QUEUED  = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_HANDED  = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_ERROR   = 3'd5;

  typedef struct packed {
    logic [1:0]       command;
    logic [REQ_W-1:0] requester;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             grant_valid;
    logic [REQ_W-1:0] grant_requester;
    logic [4:0]       waiting_count;
  } out_beat_t;

endpackage

>>> rtl/ffla_ring_ram.sv
// ----------------------------------------------------------------------------
// ffla_ring_ram
// Single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffla_ring_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 4,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/fifo_fair_lock_arbiter.sv
// ----------------------------------------------------------------------------
// fifo_fair_lock_arbiter
// Fair lock: grants first come, first served, waiters held in a RAM ring.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one command beat (lock,
// try lock, unlock) with a requester number. Every beat yields exactly one
// result beat on out_valid/out_stall/out_data: status, grant flag, granted
// requester and the number of waiters left.
// An accepted beat's result is registered straight into the output register.
// An unlock that hands the lock on first reads the ring RAM head entry into
// the registered read port; in_stall is high until the output takes it.
// Throughput: one beat per cycle while out_stall is low, except that after a
// hand-over no new beat is taken until its result is loaded from the RAM.
// The output register holds a result while out_stall is high; a new beat is
// taken in the same cycle that the waiting result is taken.
// Reset (rst_n low, synchronous): lock free, queue empty, no result pending.
// The ring RAM itself is not cleared; only entries written are ever read.
// ----------------------------------------------------------------------------
module fifo_fair_lock_arbiter
  import ffla_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam logic [QSUM_W-1:0] DEPTH_S = QSUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [8:0]        REQ_LIM = 9'(REQUESTERS);

  logic              held_r,  held_nxt;
  logic [QIDX_W-1:0] head_r,  head_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic              pend_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic              in_acc;
  logic              req_ok;
  logic              wr_en;
  logic              rd_en;
  logic [QSUM_W-1:0] tail_sum;
  logic [QSUM_W-1:0] head_sum;
  logic [QIDX_W-1:0] tail_idx;
  logic [QIDX_W-1:0] head_inc;
  logic [REQ_W-1:0]  rd_data;
  out_beat_t         res;

  assign in_stall = pend_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign req_ok   = {5'b0, in_data.requester} < REQ_LIM;

  // wrap head + count back into the ring
  assign tail_sum = QSUM_W'(head_r) + QSUM_W'(cnt_r);
  assign tail_idx = (tail_sum >= DEPTH_S) ? QIDX_W'(tail_sum - DEPTH_S)
                                          : QIDX_W'(tail_sum);
  assign head_sum = QSUM_W'(head_r) + QSUM_W'(1);
  assign head_inc = (head_sum >= DEPTH_S) ? QIDX_W'(head_sum - DEPTH_S)
                                          : QIDX_W'(head_sum);

  always_comb begin
    held_nxt            = held_r;
    head_nxt            = head_r;
    cnt_nxt             = cnt_r;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    res.status          = ST_ERROR;
    res.grant_valid     = 1'b0;
    res.grant_requester = '0;
    if (in_acc && req_ok) begin
      if (in_data.command == CMD_LOCK || in_data.command == CMD_TRY) begin
        if (!held_r && cnt_r == '0) begin
          held_nxt            = 1'b1;
          res.status          = ST_GRANTED;
          res.grant_valid     = 1'b1;
          res.grant_requester = in_data.requester;
        end else if (in_data.command == CMD_TRY) begin
          res.status = ST_REFUSED;
        end else if (cnt_r < DEPTH_C) begin
          wr_en      = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
          res.status = ST_QUEUED;
        end
      end else if (in_data.command == CMD_UNLOCK && held_r) begin
        if (cnt_r != '0) begin
          // hand over: head entry comes back from the RAM next cycle
          rd_en    = 1'b1;
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end else begin
          held_nxt   = 1'b0;
          res.status = ST_FREED;
        end
      end
    end
    res.waiting_count = 5'(cnt_nxt);
  end

  ffla_ring_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (REQ_W),
    .ADDR_W (QIDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_idx),
    .wr_data (in_data.requester),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      head_r <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_r) begin
      // output is free here: the hand-over beat was taken with it empty or draining
      out_valid_r                <= 1'b1;
      out_data_r.status          <= ST_HANDED;
      out_data_r.grant_valid     <= 1'b1;
      out_data_r.grant_requester <= rd_data;
      out_data_r.waiting_count   <= 5'(cnt_r);
    end else if (in_acc && !rd_en) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("waiter count beyond queue depth");

  a_wait_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> held_r)
    else $error("waiters queued while lock is free");

  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> (out_valid_r && out_data_r.status == ST_HANDED
                && out_data_r.grant_valid))
    else $error("hand-over result not delivered after RAM read");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !pend_r) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result overwritten");

endmodule

>>> dv/ffla_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffla_checker
// Watches both channels of the lock arbiter, predicts and compares results.
// ----------------------------------------------------------------------------
// Every command beat taken on the input channel is run through a local model
// of the lock (held flag, waiter ring, head and count). The outcome joins a
// queue of due results. Each result beat taken on the output channel is
// compared field by field with the oldest due result.
// ----------------------------------------------------------------------------
module ffla_checker
  import ffla_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending,
  output int        checked,
  output int        full_rejects
);

  localparam int PRINT_CAP = 20;

  logic             lock_busy;
  logic [REQ_W-1:0] waiters [QUEUE_DEPTH];
  int               head_idx;
  int               wait_cnt;
  out_beat_t        due_results [$];

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  // Advance the local lock model by one command and return its result.
  function automatic out_beat_t lock_outcome(in_beat_t b);
    out_beat_t r;
    r.status          = ST_ERROR;
    r.grant_valid     = 1'b0;
    r.grant_requester = '0;
    if (int'(b.requester) < REQUESTERS) begin
      if (b.command == CMD_LOCK || b.command == CMD_TRY) begin
        if (!lock_busy && wait_cnt == 0) begin
          lock_busy         = 1'b1;
          r.status          = ST_GRANTED;
          r.grant_valid     = 1'b1;
          r.grant_requester = b.requester;
        end else if (b.command == CMD_TRY) begin
          r.status = ST_REFUSED;
        end else if (wait_cnt < QUEUE_DEPTH) begin
          waiters[(head_idx + wait_cnt) % QUEUE_DEPTH] = b.requester;
          wait_cnt++;
          r.status = ST_QUEUED;
        end
      end else if (b.command == CMD_UNLOCK && lock_busy) begin
        if (wait_cnt > 0) begin
          r.grant_requester = waiters[head_idx];
          r.grant_valid     = 1'b1;
          head_idx          = (head_idx + 1) % QUEUE_DEPTH;
          wait_cnt--;
          r.status          = ST_HANDED;
        end else begin
          lock_busy = 1'b0;
          r.status  = ST_FREED;
        end
      end
    end
    r.waiting_count = 5'(wait_cnt);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    out_beat_t got;
    if (!rst_n) begin
      lock_busy    = 1'b0;
      head_idx     = 0;
      wait_cnt     = 0;
      fail_count   = 0;
      checked      = 0;
      full_rejects = 0;
      due_results.delete();
    end else begin
      // Compare first: a result never belongs to a beat taken on this edge.
      if (out_valid && !out_stall) begin
        got = out_data;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing due", got));
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
          if (got.grant_valid !== want.grant_valid)
            report_mismatch($sformatf("grant_valid got %0d want %0d",
                                      got.grant_valid, want.grant_valid));
          if (got.grant_requester !== want.grant_requester)
            report_mismatch($sformatf("grant_requester got %0d want %0d",
                                      got.grant_requester, want.grant_requester));
          if (got.waiting_count !== want.waiting_count)
            report_mismatch($sformatf("waiting_count got %0d want %0d",
                                      got.waiting_count, want.waiting_count));
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        want = lock_outcome(in_data);
        if (in_data.command == CMD_LOCK && want.status == ST_ERROR) full_rejects++;
        due_results.push_back(want);
      end
    end
    pending = due_results.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the first-come first-served lock arbiter.
// ----------------------------------------------------------------------------
// A directed run grants, refuses, hands over, frees, fills the queue and
// sends unlock-while-free and the unused command. Random bursts with a
// changing share of lock requests follow, over three handshake phases:
// slow receiver, slow sender, then no idling at all.
// ----------------------------------------------------------------------------
module tb;
  import ffla_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASE_ITEMS = 530;
  localparam int         BURST_LEN   = 24;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_data;

  int fail_count;
  int pending;
  int checked;
  int full_rejects;
  int tx_idle_pct  = 19;
  int rx_idle_pct  = 73;
  int beats_sent   = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  fifo_fair_lock_arbiter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ffla_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .full_rejects (full_rejects)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Drop the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [REQ_W-1:0] req);
    logic placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= {cmd, req};
        placed   = 1'b1;
      end
    end
    // Hold the beat until it is taken.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic run_random(int n);
    int         plock;
    int         r;
    logic [1:0] cmd;
    plock = 45;
    for (int i = 0; i < n; i++) begin
      // Vary the lock share per burst so the queue both fills and drains.
      if (i % BURST_LEN == 0) plock = 20 + 25 * $urandom_range(3);
      r = $urandom_range(99);
      if (r < plock)                         cmd = CMD_LOCK;
      else if (r < plock + (100 - plock) / 4) cmd = CMD_TRY;
      else if (r < 98)                       cmd = CMD_UNLOCK;
      else                                   cmd = CMD_UNUSED;
      send_beat(cmd, REQ_W'($urandom_range(REQUESTERS - 1)));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(CMD_LOCK,   4'd0);   // granted
    send_beat(CMD_UNLOCK, 4'd5);   // freed, from a non-holder
    send_beat(CMD_UNLOCK, 4'd0);   // unlock while free
    send_beat(CMD_UNUSED, 4'd15);  // unknown command
    send_beat(CMD_TRY,    4'd15);  // granted by try
    send_beat(CMD_LOCK,   4'd15);  // holder queues behind itself
    send_beat(CMD_UNLOCK, 4'd0);   // handed over
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_beat(CMD_LOCK, REQ_W'(QUEUE_DEPTH - 1 - i));
    end
    send_beat(CMD_LOCK,   4'd7);   // queue full
    send_beat(CMD_TRY,    4'd8);   // refused
    send_beat(CMD_UNUSED, 4'd0);

    run_random(PHASE_ITEMS);
    tx_idle_pct = 73;
    rx_idle_pct = 19;
    run_random(PHASE_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PHASE_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d command beats over three handshake phases; %0d results compared.",
             beats_sent, checked);
    $display("Lock requests rejected on a full queue: %0d; mismatches: %0d.",
             full_rejects, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
